### rtl/text_mode_cell_buffer_macros.svh
// Assertion macros shared by the checker of the character cell buffer.
`ifndef TEXT_MODE_CELL_BUFFER_MACROS_SVH
`define TEXT_MODE_CELL_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TMCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define TMCB_ASSERT_TWO(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### rtl/tmcb_pkg.sv
// Shared types, constants and lookup functions of the character cell buffer.
`default_nettype none

package tmcb_pkg;

    // Store geometry
    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COLS_W     = $clog2(MAX_COLS + 1);
    localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
    localparam int ROW_IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W     = ROW_IDX_W + COLS_W + 1;
    localparam int TOT_W      = COLS_W + ROWS_W;

    // Field widths
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 8;
    localparam int GLYPH_W   = 21;
    localparam int COLOUR_W  = 8;
    localparam int ATTR_W    = 8;
    localparam int KIND_W    = 2;
    localparam int COLUMNS_W = 8;
    localparam int ROWCNT_W  = 7;
    localparam int CELL_W    = GLYPH_W + 2 * COLOUR_W + ATTR_W;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(1);
    localparam logic [COLUMNS_W-1:0] COLUMNS_RST   = COLUMNS_W'(80);
    localparam logic [ROWCNT_W-1:0]  ROW_COUNT_RST = ROWCNT_W'(25);

    // Attribute bits
    localparam int BIT_BOLD   = 0;
    localparam int BIT_ITALIC = 1;
    localparam int BIT_BLINK  = 2;

    // Cell contents written by a clear
    localparam logic [GLYPH_W-1:0]  GLYPH_SPACE = GLYPH_W'(32'h20);
    localparam logic [COLOUR_W-1:0] FG_CLEAR    = COLOUR_W'(7);

    // Codepoints with special rendering
    localparam logic [GLYPH_W-1:0] GL_H      = GLYPH_W'(32'h2500);
    localparam logic [GLYPH_W-1:0] GL_V      = GLYPH_W'(32'h2502);
    localparam logic [GLYPH_W-1:0] GL_DR     = GLYPH_W'(32'h250C);
    localparam logic [GLYPH_W-1:0] GL_DL     = GLYPH_W'(32'h2510);
    localparam logic [GLYPH_W-1:0] GL_UR     = GLYPH_W'(32'h2514);
    localparam logic [GLYPH_W-1:0] GL_UL     = GLYPH_W'(32'h2518);
    localparam logic [GLYPH_W-1:0] GL_VR     = GLYPH_W'(32'h251C);
    localparam logic [GLYPH_W-1:0] GL_VL     = GLYPH_W'(32'h2524);
    localparam logic [GLYPH_W-1:0] GL_DH     = GLYPH_W'(32'h252C);
    localparam logic [GLYPH_W-1:0] GL_UH     = GLYPH_W'(32'h2534);
    localparam logic [GLYPH_W-1:0] GL_VH     = GLYPH_W'(32'h253C);
    localparam logic [GLYPH_W-1:0] GL_BLOCK  = GLYPH_W'(32'h2588);
    // Box drawing range is one aligned block of 128 codepoints
    localparam int BOX_LOW_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE  = 3'd0,
        FN_READ   = 3'd1,
        FN_CLEAR  = 3'd2,
        FN_SWAP   = 3'd3,
        FN_RENDER = 3'd4
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        TK_NONE  = 2'd0,
        TK_GLYPH = 2'd1,
        TK_BLOCK = 2'd2,
        TK_BOX   = 2'd3
    } t_text_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LOOKUP,
        ST_CLEAR,
        ST_SWAP
    } t_state;

    typedef struct packed {
        logic [GLYPH_W-1:0]  glyph;
        logic [COLOUR_W-1:0] fg;
        logic [COLOUR_W-1:0] bg;
        logic [ATTR_W-1:0]   attr;
    } t_cell;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [POS_W-1:0]    col_pos;
        logic [POS_W-1:0]    row_pos;
        logic [GLYPH_W-1:0]  glyph_in;
        logic [COLOUR_W-1:0] fg_in;
        logic [COLOUR_W-1:0] bg_in;
        logic [ATTR_W-1:0]   attr_in;
        logic                blink_on;
    } t_req_data;

    typedef struct packed {
        logic [GLYPH_W-1:0]  glyph_out;
        logic [COLOUR_W-1:0] fg_out;
        logic [COLOUR_W-1:0] bg_out;
        logic [ATTR_W-1:0]   attr_out;
        logic                paint_bg;
        logic [KIND_W-1:0]   text_kind;
        logic                seg_left;
        logic                seg_right;
        logic                seg_up;
        logic                seg_down;
        logic                bold_on;
        logic                italic_on;
    } t_rsp_data;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // latch the item and its position check
        logic write_item;  // write the item into the back store when in range
        logic sweep_clr;   // restart the sweep counter
        logic init_step;   // zero one entry of both stores
        logic clear_step;  // fill one back entry with the clear cell
        logic copy_step;   // read one back entry for copying to the front
        logic load_zero;   // load an all-zero response
        logic load_cell;   // load the looked-up response
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic init_last;   // sweep counter on the last store entry
        logic sweep_end;   // sweep counter has covered every cell in use
    } t_dp_stat;

    typedef struct packed {
        logic left;
        logic right;
        logic up;
        logic down;
    } t_segs;

    // Line pieces carried by each box drawing codepoint
    function automatic t_segs box_segs(input logic [GLYPH_W-1:0] g);
        t_segs s;
        s = '0;
        case (g)
            GL_H:    begin s.left = 1'b1; s.right = 1'b1; end
            GL_V:    begin s.up = 1'b1;   s.down = 1'b1;  end
            GL_DR:   begin s.right = 1'b1; s.down = 1'b1; end
            GL_DL:   begin s.left = 1'b1;  s.down = 1'b1; end
            GL_UR:   begin s.right = 1'b1; s.up = 1'b1;   end
            GL_UL:   begin s.left = 1'b1;  s.up = 1'b1;   end
            GL_VR:   begin s.right = 1'b1; s.up = 1'b1; s.down = 1'b1; end
            GL_VL:   begin s.left = 1'b1;  s.up = 1'b1; s.down = 1'b1; end
            GL_DH:   begin s.left = 1'b1; s.right = 1'b1; s.down = 1'b1; end
            GL_UH:   begin s.left = 1'b1; s.right = 1'b1; s.up = 1'b1;   end
            GL_VH:   s = '1;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/tmcb_ifs.sv
// Valid/ready channel interfaces: request, response and configuration.
`default_nettype none

interface tmcb_req_if import tmcb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [POS_W-1:0]    col_pos;
    logic [POS_W-1:0]    row_pos;
    logic [GLYPH_W-1:0]  glyph_in;
    logic [COLOUR_W-1:0] fg_in;
    logic [COLOUR_W-1:0] bg_in;
    logic [ATTR_W-1:0]   attr_in;
    logic                blink_on;

    modport source (
        output valid, func, col_pos, row_pos, glyph_in, fg_in, bg_in, attr_in, blink_on,
        input  ready
    );
    modport sink (
        input  valid, func, col_pos, row_pos, glyph_in, fg_in, bg_in, attr_in, blink_on,
        output ready
    );
endinterface

interface tmcb_rsp_if import tmcb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [GLYPH_W-1:0]  glyph_out;
    logic [COLOUR_W-1:0] fg_out;
    logic [COLOUR_W-1:0] bg_out;
    logic [ATTR_W-1:0]   attr_out;
    logic                paint_bg;
    logic [KIND_W-1:0]   text_kind;
    logic                seg_left;
    logic                seg_right;
    logic                seg_up;
    logic                seg_down;
    logic                bold_on;
    logic                italic_on;

    modport source (
        output valid, glyph_out, fg_out, bg_out, attr_out, paint_bg, text_kind,
               seg_left, seg_right, seg_up, seg_down, bold_on, italic_on,
        input  ready
    );
    modport sink (
        input  valid, glyph_out, fg_out, bg_out, attr_out, paint_bg, text_kind,
               seg_left, seg_right, seg_up, seg_down, bold_on, italic_on,
        output ready
    );
endinterface

interface tmcb_cfg_if import tmcb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/tmcb_ctrl.sv
// Controller: sequences item handling, store sweeps and the response register.
`default_nettype none

module tmcb_ctrl import tmcb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [FUNC_W-1:0] i_req_func,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   w_ready;

    // State and response flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        w_ready     = 1'b0;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // take a new beat once the response register is free or draining
                w_ready = !r_rsp_valid || i_rsp_ready;
                if (w_ready && i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    case (t_func'(i_req_func))
                        FN_WRITE: begin
                            o_cmd.write_item = 1'b1;
                            o_cmd.load_zero  = 1'b1;
                            n_rsp_valid      = 1'b1;
                        end
                        FN_READ, FN_RENDER: begin
                            n_state = ST_LOOKUP;
                        end
                        FN_CLEAR: begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = ST_CLEAR;
                        end
                        FN_SWAP: begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = ST_SWAP;
                        end
                        default: begin
                            o_cmd.load_zero = 1'b1;
                            n_rsp_valid     = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                o_cmd.load_cell = 1'b1;
                n_rsp_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_CLEAR: begin
                if (i_stat.sweep_end) begin
                    o_cmd.load_zero = 1'b1;
                    n_rsp_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.clear_step = 1'b1;
                end
            end
            ST_SWAP: begin
                // the last copied entry lands in the front store on the exit edge
                if (i_stat.sweep_end) begin
                    o_cmd.load_zero = 1'b1;
                    n_rsp_valid     = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_req_ready = w_ready;
    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

### rtl/tmcb_dp.sv
// Datapath: configuration, cell stores, address arithmetic, render lookup, response.
`default_nettype none

module tmcb_dp import tmcb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req_data             i_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_rsp_data             o_rsp
);

    // Configuration
    logic [COLUMNS_W-1:0] r_columns;
    logic [ROWCNT_W-1:0]  r_row_count;

    // Cell stores and their registered read data
    logic [CELL_W-1:0] r_back_mem  [CELL_COUNT];
    logic [CELL_W-1:0] r_front_mem [CELL_COUNT];
    t_cell             r_back_q;
    t_cell             r_front_q;

    // Sweep and copy pipeline
    logic [CNT_W-1:0]  r_cnt;
    logic              r_copy_pend;
    logic [ADDR_W-1:0] r_copy_addr;

    // Item latched at accept
    t_func             r_func_lat;
    logic              r_hit_lat;
    logic              r_blink_lat;
    logic [COLOUR_W-1:0] r_bg_lat;

    t_rsp_data         r_rsp;

    logic [COLS_W-1:0] w_cols_eff;
    logic [ROWS_W-1:0] w_rows_eff;
    logic [TOT_W-1:0]  w_total;
    logic [PROD_W-1:0] w_prod;
    logic [ADDR_W-1:0] w_idx;
    logic [ADDR_W-1:0] w_sweep_addr;
    logic              w_hit;

    logic              w_back_we;
    logic [ADDR_W-1:0] w_back_waddr;
    t_cell             w_back_wdata;
    logic [ADDR_W-1:0] w_back_raddr;
    logic              w_front_we;
    logic [ADDR_W-1:0] w_front_waddr;
    t_cell             w_front_wdata;

    t_cell             w_cell;
    t_segs             w_segs;
    logic              w_hidden;
    t_rsp_data         w_lookup;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= COLUMNS_RST;
            r_row_count <= ROW_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLUMNS:   r_columns   <= i_cfg_data[COLUMNS_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROWCNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective sizes, position check and linear cell index
    always_comb begin
        w_cols_eff = (r_columns > MAX_COLS) ? COLS_W'(MAX_COLS) : COLS_W'(r_columns);
        w_rows_eff = (r_row_count > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : ROWS_W'(r_row_count);
        w_total    = TOT_W'(w_cols_eff) * TOT_W'(w_rows_eff);
        w_hit      = (i_req.col_pos < w_cols_eff) && (i_req.row_pos < w_rows_eff);
        w_prod     = PROD_W'(i_req.row_pos[ROW_IDX_W-1:0]) * PROD_W'(w_cols_eff)
                   + PROD_W'(i_req.col_pos);
        w_idx        = w_prod[ADDR_W-1:0];
        w_sweep_addr = r_cnt[ADDR_W-1:0];
    end

    assign o_stat.init_last = (r_cnt == CNT_W'(CELL_COUNT - 1));
    assign o_stat.sweep_end = (TOT_W'(r_cnt) >= w_total);

    // Restart or advance the sweep counter and flag a pending copy write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_copy_pend <= 1'b0;
        end else begin
            if (i_cmd.sweep_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.init_step || i_cmd.clear_step || i_cmd.copy_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_copy_pend <= i_cmd.copy_step;
        end
    end

    // Latch the copy address and the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_step) begin
            r_copy_addr <= w_sweep_addr;
        end
        if (i_cmd.accept) begin
            r_func_lat  <= t_func'(i_req.func);
            r_hit_lat   <= w_hit;
            r_blink_lat <= i_req.blink_on;
            r_bg_lat    <= i_req.bg_in;
        end
    end

    // Back store port selection
    always_comb begin
        w_back_we    = i_cmd.init_step || i_cmd.clear_step || (i_cmd.write_item && w_hit);
        w_back_waddr = w_idx;
        w_back_wdata.glyph = i_req.glyph_in;
        w_back_wdata.fg    = i_req.fg_in;
        w_back_wdata.bg    = i_req.bg_in;
        w_back_wdata.attr  = i_req.attr_in;
        if (i_cmd.init_step) begin
            w_back_waddr = w_sweep_addr;
            w_back_wdata = '0;
        end else if (i_cmd.clear_step) begin
            w_back_waddr       = w_sweep_addr;
            w_back_wdata.glyph = GLYPH_SPACE;
            w_back_wdata.fg    = FG_CLEAR;
            w_back_wdata.bg    = r_bg_lat;
            w_back_wdata.attr  = '0;
        end
        w_back_raddr = i_cmd.copy_step ? w_sweep_addr : w_idx;
    end

    // Front store port selection
    always_comb begin
        w_front_we    = i_cmd.init_step || r_copy_pend;
        w_front_waddr = i_cmd.init_step ? w_sweep_addr : r_copy_addr;
        w_front_wdata = i_cmd.init_step ? t_cell'('0) : r_back_q;
    end

    // Back store
    always_ff @(posedge i_clk) begin
        if (w_back_we) begin
            r_back_mem[w_back_waddr] <= w_back_wdata;
        end
        r_back_q <= t_cell'(r_back_mem[w_back_raddr]);
    end

    // Front store
    always_ff @(posedge i_clk) begin
        if (w_front_we) begin
            r_front_mem[w_front_waddr] <= w_front_wdata;
        end
        r_front_q <= t_cell'(r_front_mem[w_idx]);
    end

    // Read and render lookup of the fetched cell
    always_comb begin
        w_cell   = (r_func_lat == FN_RENDER) ? r_front_q : r_back_q;
        w_segs   = box_segs(w_cell.glyph);
        w_hidden = (w_cell.glyph == '0) || (w_cell.glyph == GLYPH_SPACE)
                || (w_cell.attr[BIT_BLINK] && !r_blink_lat);
        w_lookup = '0;
        if (r_hit_lat) begin
            w_lookup.glyph_out = w_cell.glyph;
            w_lookup.fg_out    = w_cell.fg;
            w_lookup.bg_out    = w_cell.bg;
            w_lookup.attr_out  = w_cell.attr;
            if (r_func_lat == FN_RENDER) begin
                w_lookup.paint_bg = (w_cell.bg != '0);
                if (!w_hidden) begin
                    if (w_cell.glyph == GL_BLOCK) begin
                        w_lookup.text_kind = TK_BLOCK;
                    end else if (w_cell.glyph[GLYPH_W-1:BOX_LOW_W]
                                 == GL_H[GLYPH_W-1:BOX_LOW_W]) begin
                        w_lookup.text_kind = TK_BOX;
                        w_lookup.seg_left  = w_segs.left;
                        w_lookup.seg_right = w_segs.right;
                        w_lookup.seg_up    = w_segs.up;
                        w_lookup.seg_down  = w_segs.down;
                    end else begin
                        w_lookup.text_kind = TK_GLYPH;
                        w_lookup.bold_on   = w_cell.attr[BIT_BOLD];
                        w_lookup.italic_on = w_cell.attr[BIT_ITALIC];
                    end
                end
            end
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_zero) begin
            r_rsp <= '0;
        end else if (i_cmd.load_cell) begin
            r_rsp <= w_lookup;
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

### rtl/text_mode_cell_buffer.sv
// Text mode character cell buffer: double-buffered cell store with render lookup.
//
// Two stores of 128 x 64 cells (codepoint, foreground, background, attributes).
// Write, read and clear act on the back store, swap copies back to front, and
// render classifies one front cell for drawing. After reset a clearing pass
// zeroes both stores; no request beat is taken until it ends, while
// configuration writes are taken at any time. A write, or an unknown function
// code, is answered in the cycle after it is taken. For a read or render the
// store read is registered and the lookup state then loads the response
// register. Clear and swap walk the cells in use one per cycle. Every request
// beat gives exactly one response beat; the response register holds it until
// taken, and a new request beat is taken in the cycle the previous response
// drains.
`default_nettype none

module text_mode_cell_buffer import tmcb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tmcb_cfg_if.sink   i_cfg,
    tmcb_req_if.sink   i_req,
    tmcb_rsp_if.source o_rsp
);

    t_req_data w_req;
    t_rsp_data w_rsp;
    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    logic      w_req_ready;
    logic      w_rsp_valid;

    // Gather the request payload
    always_comb begin
        w_req.func     = i_req.func;
        w_req.col_pos  = i_req.col_pos;
        w_req.row_pos  = i_req.row_pos;
        w_req.glyph_in = i_req.glyph_in;
        w_req.fg_in    = i_req.fg_in;
        w_req.bg_in    = i_req.bg_in;
        w_req.attr_in  = i_req.attr_in;
        w_req.blink_on = i_req.blink_on;
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_req_ready;

    tmcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (w_req_ready),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tmcb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_req       (w_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_rsp       (w_rsp)
    );

    // Drive the response channel
    assign o_rsp.valid     = w_rsp_valid;
    assign o_rsp.glyph_out = w_rsp.glyph_out;
    assign o_rsp.fg_out    = w_rsp.fg_out;
    assign o_rsp.bg_out    = w_rsp.bg_out;
    assign o_rsp.attr_out  = w_rsp.attr_out;
    assign o_rsp.paint_bg  = w_rsp.paint_bg;
    assign o_rsp.text_kind = w_rsp.text_kind;
    assign o_rsp.seg_left  = w_rsp.seg_left;
    assign o_rsp.seg_right = w_rsp.seg_right;
    assign o_rsp.seg_up    = w_rsp.seg_up;
    assign o_rsp.seg_down  = w_rsp.seg_down;
    assign o_rsp.bold_on   = w_rsp.bold_on;
    assign o_rsp.italic_on = w_rsp.italic_on;

endmodule

`default_nettype wire

### rtl/tmcb_checker.sv
// Port-level checker of the character cell buffer and its bind to the top level.
`default_nettype none
`include "text_mode_cell_buffer_macros.svh"

module tmcb_checker import tmcb_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic [FUNC_W-1:0]   i_req_func,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [GLYPH_W-1:0]  i_rsp_glyph,
    input logic [COLOUR_W-1:0] i_rsp_fg,
    input logic [KIND_W-1:0]   i_rsp_kind
);

    logic w_acc;
    logic w_rsp_stall;

    assign w_acc       = i_req_valid && i_req_ready;
    assign w_rsp_stall = i_rsp_valid && !i_rsp_ready;

    // A stalled response beat holds its payload
    `TMCB_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, w_rsp_stall, i_rsp_valid && $stable(i_rsp_glyph) && $stable(i_rsp_fg), "stalled response changed")

    // No request beat while a response beat waits
    `TMCB_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, w_rsp_stall, !i_req_ready, "request taken over pending response")

    // A write answers in the next cycle with an empty result
    `TMCB_ASSERT_NEXT(a_write_rsp, i_clk, i_rst_n, w_acc && i_req_func == FN_WRITE, i_rsp_valid && i_rsp_glyph == '0 && i_rsp_kind == TK_NONE, "bad write response")

    // A read or render answers after the registered store read and the lookup state
    `TMCB_ASSERT_TWO(a_lookup_rsp, i_clk, i_rst_n, w_acc && (i_req_func == FN_READ || i_req_func == FN_RENDER), i_rsp_valid, "lookup response late")

endmodule

bind text_mode_cell_buffer tmcb_checker u_tmcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_func  (i_req.func),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_glyph (o_rsp.glyph_out),
    .i_rsp_fg    (o_rsp.fg_out),
    .i_rsp_kind  (o_rsp.text_kind)
);

`default_nettype wire
